@@ rtl/m3inv_pkg.sv @@
// Package for the 3x3 matrix inverse: request and response types and constants.
package m3inv_pkg;

   localparam int unsigned ElemWidth = 32;
   localparam int unsigned DivSteps  = 32;
   localparam int unsigned FrontStages = 7;
   localparam int unsigned PipeDepth = FrontStages + DivSteps + 1;

   localparam logic [31:0] Q_ONE   = 32'h0001_0000;
   localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_NEG = 32'h8000_0000;

   // Operand indexes of the eighteen cofactor products, in column-major element order.
   // Product 2*i minus product 2*i+1 gives adjugate entry i.
   localparam logic [3:0] PROD_A [18] = '{
      4'd4, 4'd5, 4'd2, 4'd1, 4'd1, 4'd2, 4'd5, 4'd3, 4'd0,
      4'd2, 4'd2, 4'd0, 4'd3, 4'd4, 4'd1, 4'd0, 4'd0, 4'd1};
   localparam logic [3:0] PROD_B [18] = '{
      4'd8, 4'd7, 4'd7, 4'd8, 4'd5, 4'd4, 4'd6, 4'd8, 4'd8,
      4'd6, 4'd3, 4'd5, 4'd7, 4'd6, 4'd6, 4'd7, 4'd4, 4'd3};

   typedef struct packed {
      logic signed [31:0] a_r0c0;
      logic signed [31:0] a_r1c0;
      logic signed [31:0] a_r2c0;
      logic signed [31:0] a_r0c1;
      logic signed [31:0] a_r1c1;
      logic signed [31:0] a_r2c1;
      logic signed [31:0] a_r0c2;
      logic signed [31:0] a_r1c2;
      logic signed [31:0] a_r2c2;
   } req_type;

   typedef struct packed {
      logic signed [31:0] inv_r0c0;
      logic signed [31:0] inv_r1c0;
      logic signed [31:0] inv_r2c0;
      logic signed [31:0] inv_r0c1;
      logic signed [31:0] inv_r1c1;
      logic signed [31:0] inv_r2c1;
      logic signed [31:0] inv_r0c2;
      logic signed [31:0] inv_r1c2;
      logic signed [31:0] inv_r2c2;
      logic               singular;
   } rsp_type;

endpackage

@@ rtl/matrix3x3_inverse_top.sv @@
// Throughput: one request per cycle unless stalled; 7 arithmetic stages, then 32
// restoring division stages (one quotient bit each), then a saturating output register.
// The whole pipeline advances together and freezes while a response is stalled.
// Reset clears the valid bits only; the data registers are not reset.
// Top level of the 3x3 Q16.16 matrix inverse pipeline.
module matrix3x3_inverse_top
   import m3inv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef struct packed {
      logic              sing;
      logic [96:0]       dmag;
      logic [8:0]        neg;
      logic [8:0]        big;
      logic [8:0][97:0]  rem;
      logic [8:0][31:0]  quo;
   } div_type;

   logic                  adv;
   logic [PipeDepth-1:0]  vld_ff;
   logic [PipeDepth-1:0]  vld_in;

   logic signed [31:0]    m [9];

   // Stage registers.
   logic signed [63:0]    p1_ff [18];
   logic signed [31:0]    m1_ff [3];
   logic signed [63:0]    n2_ff [9];
   logic signed [31:0]    m2_ff [3];
   logic signed [63:0]    n3_ff [9];
   logic signed [64:0]    lo3_ff [3];
   logic signed [63:0]    hi3_ff [3];
   logic signed [63:0]    n4_ff [9];
   logic signed [96:0]    t4_ff [3];
   logic signed [63:0]    n5_ff [9];
   logic signed [97:0]    d5_ff;
   logic [8:0]            ns6_ff;
   logic [8:0][63:0]      nm6_ff;
   logic                  dneg6_ff;
   logic                  dzero6_ff;
   logic [96:0]           dmag6_ff;
   div_type               div_ff [DivSteps+1];
   div_type               div_in [DivSteps+1];
   div_type               div0_in;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;

   // The pipeline moves unless the output holds a response that is stalled.
   assign adv       = !(vld_ff[PipeDepth-1] && rsp_stall);
   assign req_stall = !adv;
   assign vld_in    = {vld_ff[PipeDepth-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   assign m[0] = req_data.a_r0c0;
   assign m[1] = req_data.a_r1c0;
   assign m[2] = req_data.a_r2c0;
   assign m[3] = req_data.a_r0c1;
   assign m[4] = req_data.a_r1c1;
   assign m[5] = req_data.a_r2c1;
   assign m[6] = req_data.a_r0c2;
   assign m[7] = req_data.a_r1c2;
   assign m[8] = req_data.a_r2c2;

   // Stage 1: the eighteen 32x32 cofactor products.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 18; k++) begin
            p1_ff[k] <= m[PROD_A[k]] * m[PROD_B[k]];
         end
         for (int k = 0; k < 3; k++) begin
            m1_ff[k] <= m[k];
         end
      end
   end

   // Stage 2: adjugate entries as differences of products.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 9; i++) begin
            n2_ff[i] <= p1_ff[2*i] - p1_ff[2*i+1];
         end
         m2_ff <= m1_ff;
      end
   end

   // Stage 3: first-column elements times cofactors, split into 32-bit halves.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            lo3_ff[k] <= 65'(m2_ff[k] * $signed({1'b0, n2_ff[3*k][31:0]}));
            hi3_ff[k] <= m2_ff[k] * $signed(n2_ff[3*k][63:32]);
         end
         n3_ff <= n2_ff;
      end
   end

   // Stage 4: recombine the halves of each determinant term.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            t4_ff[k] <= $signed({hi3_ff[k][63], hi3_ff[k], 32'b0})
                      + $signed({{32{lo3_ff[k][64]}}, lo3_ff[k]});
         end
         n4_ff <= n3_ff;
      end
   end

   // Stage 5: the determinant.
   always_ff @(posedge clock) begin
      if (adv) begin
         d5_ff <= 98'(t4_ff[0]) + 98'(t4_ff[1]) + 98'(t4_ff[2]);
         n5_ff <= n4_ff;
      end
   end

   // Stage 6: signs and magnitudes.
   always_ff @(posedge clock) begin
      if (adv) begin
         dneg6_ff  <= d5_ff[97];
         dzero6_ff <= (d5_ff == '0);
         dmag6_ff  <= d5_ff[97] ? 97'(-d5_ff) : d5_ff[96:0];
         for (int i = 0; i < 9; i++) begin
            ns6_ff[i] <= n5_ff[i][63];
            nm6_ff[i] <= n5_ff[i][63] ? 64'(-n5_ff[i]) : 64'(n5_ff[i]);
         end
      end
   end

   // Stage 7: catch quotients of 2^32 or more and seed the dividers.
   always_comb begin
      div0_in.sing = dzero6_ff;
      div0_in.dmag = dmag6_ff;
      for (int i = 0; i < 9; i++) begin
         div0_in.neg[i] = ns6_ff[i] ^ dneg6_ff;
         div0_in.big[i] = ({33'b0, nm6_ff[i]} >= dmag6_ff);
         div0_in.rem[i] = div0_in.big[i] ? 98'b0 : {34'b0, nm6_ff[i]};
         div0_in.quo[i] = '0;
      end
   end

   assign div_in[0] = div0_in;

   always_ff @(posedge clock) begin
      if (adv) begin
         div_ff[0] <= div_in[0];
      end
   end

   // Restoring division, one quotient bit per stage for all nine entries.
   for (genvar j = 0; j < DivSteps; j++) begin : g_div
      logic [8:0][97:0] shl;
      logic [8:0]       ge;

      always_comb begin
         div_in[j+1] = div_ff[j];
         for (int i = 0; i < 9; i++) begin
            shl[i] = {div_ff[j].rem[i][96:0], 1'b0};
            ge[i]  = (shl[i] >= {1'b0, div_ff[j].dmag});
            div_in[j+1].rem[i] = ge[i] ? 98'(shl[i] - {1'b0, div_ff[j].dmag}) : shl[i];
            div_in[j+1].quo[i] = {div_ff[j].quo[i][30:0], ge[i]};
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            div_ff[j+1] <= div_in[j+1];
         end
      end
   end

   // Output stage: sign, saturation and the singular case.
   always_comb begin
      logic [8:0][31:0] res;
      div_type          dv;
      dv = div_ff[DivSteps];
      for (int i = 0; i < 9; i++) begin
         if (dv.sing) begin
            res[i] = (i == 0 || i == 4 || i == 8) ? Q_ONE : 32'b0;
         end else if (dv.big[i]) begin
            res[i] = dv.neg[i] ? SAT_NEG : SAT_POS;
         end else if (dv.neg[i]) begin
            res[i] = dv.quo[i][31] ? SAT_NEG : 32'(-dv.quo[i]);
         end else begin
            res[i] = dv.quo[i][31] ? SAT_POS : dv.quo[i];
         end
      end
      rsp_in.inv_r0c0 = res[0];
      rsp_in.inv_r1c0 = res[1];
      rsp_in.inv_r2c0 = res[2];
      rsp_in.inv_r0c1 = res[3];
      rsp_in.inv_r1c1 = res[4];
      rsp_in.inv_r2c1 = res[5];
      rsp_in.inv_r0c2 = res[6];
      rsp_in.inv_r1c2 = res[7];
      rsp_in.inv_r2c2 = res[8];
      rsp_in.singular = dv.sing;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = vld_ff[PipeDepth-1];
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/m3inv_checker.sv @@
// Port-level checker for the 3x3 matrix inverse, bound to the top level.
module m3inv_checker
   import m3inv_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A stalled response stays valid.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled response dropped");

   // The request side stalls exactly when a response is held back.
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall does not follow response stall");

   // A singular response carries the identity matrix.
   a_identity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.singular |->
         rsp_data.inv_r0c0 == Q_ONE && rsp_data.inv_r1c1 == Q_ONE &&
         rsp_data.inv_r2c2 == Q_ONE && rsp_data.inv_r1c0 == 0 &&
         rsp_data.inv_r2c0 == 0 && rsp_data.inv_r0c1 == 0 &&
         rsp_data.inv_r2c1 == 0 && rsp_data.inv_r0c2 == 0 &&
         rsp_data.inv_r1c2 == 0)
      else $error("singular response is not the identity");

   // No response appears in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind matrix3x3_inverse_top m3inv_checker u_m3inv_checker (.*);
